### rtl/sof_pkg.sv
package sof_pkg;

	localparam int NUM_SENSORS = 4;
	localparam int SAMPLE_BITS = 10;
	localparam int LIMIT_BITS = 18;
	localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = LIMIT_BITS'(30000);

	// The variance limit is scaled by 64 before it is compared.
	localparam int LIMIT_SHIFT = 6;

	typedef struct packed {
		logic spread_alarm;
		logic [NUM_SENSORS-1:0] low_flags;
		logic [NUM_SENSORS-1:0] high_flags;
	} result_t;

	localparam int RESULT_BITS = $bits(result_t);
	localparam int OUT_DATA_BITS = ((RESULT_BITS + 7) / 8) * 8;

endpackage

### rtl/sof_dev.sv
// Stages one and two: the sum of the readings, then each reading's
// deviation 4*x - S split into magnitude and sign.
module sof_dev #(
	parameter int SAMPLE_BITS = sof_pkg::SAMPLE_BITS
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [sof_pkg::NUM_SENSORS-1:0][SAMPLE_BITS-1:0] sample,
	output logic out_valid,
	input  logic out_ready,
	output logic [sof_pkg::NUM_SENSORS-1:0][SAMPLE_BITS+1:0] mag,
	output logic [sof_pkg::NUM_SENSORS-1:0] pos,
	output logic [sof_pkg::NUM_SENSORS-1:0] neg
);

	localparam int SUM_BITS = SAMPLE_BITS + 2;
	localparam int DEV_BITS = SAMPLE_BITS + 3;

	logic v_s1, v_s2;
	logic en_s1, en_s2;
	logic [sof_pkg::NUM_SENSORS-1:0][SAMPLE_BITS-1:0] x_s1;
	logic [SUM_BITS-1:0] sum_s1;
	logic [SUM_BITS-1:0] sum_in;
	logic [sof_pkg::NUM_SENSORS-1:0][SAMPLE_BITS+1:0] mag_s2;
	logic [sof_pkg::NUM_SENSORS-1:0] pos_s2, neg_s2;
	logic [sof_pkg::NUM_SENSORS-1:0][SAMPLE_BITS+1:0] mag_next;
	logic [sof_pkg::NUM_SENSORS-1:0] pos_next, neg_next;

	assign en_s2 = !v_s2 || out_ready;
	assign en_s1 = !v_s1 || en_s2;
	assign in_ready = en_s1;

	always_comb begin
		sum_in = '0;
		for (int i = 0; i < sof_pkg::NUM_SENSORS; i++) begin
			sum_in = sum_in + SUM_BITS'(sample[i]);
		end
	end

	always_comb begin
		logic signed [DEV_BITS-1:0] d;
		logic [DEV_BITS-1:0] a;
		for (int i = 0; i < sof_pkg::NUM_SENSORS; i++) begin
			d = $signed({1'b0, x_s1[i], 2'b00}) - $signed({1'b0, sum_s1});
			a = d[DEV_BITS-1] ? DEV_BITS'(-d) : DEV_BITS'(d);
			mag_next[i] = a[SAMPLE_BITS+1:0];
			neg_next[i] = d[DEV_BITS-1];
			pos_next[i] = !d[DEV_BITS-1] && (d != '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (en_s1) begin
				v_s1 <= in_valid;
			end
			if (en_s2) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			x_s1 <= sample;
			sum_s1 <= sum_in;
		end
		if (en_s2 && v_s1) begin
			mag_s2 <= mag_next;
			pos_s2 <= pos_next;
			neg_s2 <= neg_next;
		end
	end

	assign out_valid = v_s2;
	assign mag = mag_s2;
	assign pos = pos_s2;
	assign neg = neg_s2;

endmodule

### rtl/sof_square.sv
// Stages three and four: the square of each deviation, then the sum of
// the four squares.
module sof_square #(
	parameter int SAMPLE_BITS = sof_pkg::SAMPLE_BITS
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [sof_pkg::NUM_SENSORS-1:0][SAMPLE_BITS+1:0] mag,
	input  logic [sof_pkg::NUM_SENSORS-1:0] pos,
	input  logic [sof_pkg::NUM_SENSORS-1:0] neg,
	output logic out_valid,
	input  logic out_ready,
	output logic [sof_pkg::NUM_SENSORS-1:0][2*SAMPLE_BITS+3:0] sq,
	output logic [2*SAMPLE_BITS+5:0] sq_sum,
	output logic [sof_pkg::NUM_SENSORS-1:0] pos_out,
	output logic [sof_pkg::NUM_SENSORS-1:0] neg_out
);

	localparam int SQ_BITS = 2 * SAMPLE_BITS + 4;
	localparam int SQS_BITS = SQ_BITS + 2;

	logic v_s3, v_s4;
	logic en_s3, en_s4;
	logic [sof_pkg::NUM_SENSORS-1:0][SQ_BITS-1:0] sq_s3, sq_s4;
	logic [sof_pkg::NUM_SENSORS-1:0] pos_s3, neg_s3, pos_s4, neg_s4;
	logic [SQS_BITS-1:0] sq_sum_s4;
	logic [SQS_BITS-1:0] sum_next;
	logic [sof_pkg::NUM_SENSORS-1:0][SQ_BITS-1:0] sq_next;

	assign en_s4 = !v_s4 || out_ready;
	assign en_s3 = !v_s3 || en_s4;
	assign in_ready = en_s3;

	always_comb begin
		for (int i = 0; i < sof_pkg::NUM_SENSORS; i++) begin
			sq_next[i] = SQ_BITS'(mag[i]) * SQ_BITS'(mag[i]);
		end
	end

	always_comb begin
		sum_next = '0;
		for (int i = 0; i < sof_pkg::NUM_SENSORS; i++) begin
			sum_next = sum_next + SQS_BITS'(sq_s3[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en_s3) begin
				v_s3 <= in_valid;
			end
			if (en_s4) begin
				v_s4 <= v_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3 && in_valid) begin
			sq_s3 <= sq_next;
			pos_s3 <= pos;
			neg_s3 <= neg;
		end
		if (en_s4 && v_s3) begin
			sq_s4 <= sq_s3;
			sq_sum_s4 <= sum_next;
			pos_s4 <= pos_s3;
			neg_s4 <= neg_s3;
		end
	end

	assign out_valid = v_s4;
	assign sq = sq_s4;
	assign sq_sum = sq_sum_s4;
	assign pos_out = pos_s4;
	assign neg_out = neg_s4;

endmodule

### rtl/sof_judge.sv
// Stage five: the spread alarm and the per-sensor band checks, held in
// the output register until the receiver takes the word.
module sof_judge #(
	parameter int SAMPLE_BITS = sof_pkg::SAMPLE_BITS
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [sof_pkg::NUM_SENSORS-1:0][2*SAMPLE_BITS+3:0] sq,
	input  logic [2*SAMPLE_BITS+5:0] sq_sum,
	input  logic [sof_pkg::NUM_SENSORS-1:0] pos,
	input  logic [sof_pkg::NUM_SENSORS-1:0] neg,
	input  logic [sof_pkg::LIMIT_BITS-1:0] limit,
	output logic out_valid,
	input  logic out_ready,
	output sof_pkg::result_t result
);

	localparam int SQS_BITS = 2 * SAMPLE_BITS + 6;
	localparam int LIM_BITS = sof_pkg::LIMIT_BITS + sof_pkg::LIMIT_SHIFT;
	localparam int CMP_BITS = (SQS_BITS > LIM_BITS) ? SQS_BITS : LIM_BITS;

	logic v_s5;
	logic en_s5;
	sof_pkg::result_t res_s5;
	sof_pkg::result_t res_next;
	logic alarm;
	logic [sof_pkg::NUM_SENSORS-1:0] wide;

	assign en_s5 = !v_s5 || out_ready;
	assign in_ready = en_s5;

	assign alarm = CMP_BITS'(sq_sum) > CMP_BITS'({limit, {sof_pkg::LIMIT_SHIFT{1'b0}}});

	// A sensor is outside the band when 4*d^2 exceeds the sum of all d^2.
	always_comb begin
		for (int i = 0; i < sof_pkg::NUM_SENSORS; i++) begin
			wide[i] = {sq[i], 2'b00} > sq_sum;
		end
		res_next.spread_alarm = alarm;
		res_next.high_flags = alarm ? (wide & pos) : '0;
		res_next.low_flags = alarm ? (wide & neg) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en_s5) begin
			v_s5 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s5 && in_valid) begin
			res_s5 <= res_next;
		end
	end

	assign out_valid = v_s5;
	assign result = res_s5;

	a_flags_need_alarm: assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 && !res_s5.spread_alarm |-> (res_s5.high_flags == '0) && (res_s5.low_flags == '0))
		else $error("band flag set without spread alarm");

	a_flags_disjoint: assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 |-> (res_s5.high_flags & res_s5.low_flags) == '0)
		else $error("sensor flagged both high and low");

	// Deviations sum to zero, so not every sensor can sit on the same side.
	a_not_all_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 |-> ($countones(res_s5.high_flags) < sof_pkg::NUM_SENSORS) &&
			($countones(res_s5.low_flags) < sof_pkg::NUM_SENSORS))
		else $error("all sensors flagged on one side");

endmodule

### rtl/sensor_outlier_flagger.sv
// One-sigma outlier check over four sensor readings.
//
// While s_tready is high the s_ channel takes one word per cycle, holding four
// readings; the m_ channel returns one word per input word with the high and
// low band flags and the spread alarm. Words are taken when tvalid and tready
// are both high. The user writes the variance limit through cfg_we / cfg_wdata
// only while the block is idle, which it does not enforce; it resets to 30000.
//
// Five register stages: sum, deviation, square, sum of squares, compare. The
// accepting edge loads the first, and each word then passes through the others
// in that order to the m_ channel. Throughput is one word per cycle when the
// receiver keeps m_tready high.
//
// When the receiver stalls, the output register holds its word and each
// stage keeps its contents; empty stages still fill, so s_tready falls only
// once all five stages hold a word. Reset clears every valid bit and
// restores the limit; no words are in flight after reset.
module sensor_outlier_flagger #(
	parameter int SAMPLE_BITS = sof_pkg::SAMPLE_BITS
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// sample_a, sample_b, sample_c, sample_d, then zero fill
	input  logic [((sof_pkg::NUM_SENSORS*SAMPLE_BITS+7)/8)*8-1:0] s_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	// high_flags, low_flags, spread_alarm, then zero fill
	output logic [sof_pkg::OUT_DATA_BITS-1:0] m_tdata,
	input  logic cfg_we,
	input  logic [sof_pkg::LIMIT_BITS-1:0] cfg_wdata
);

	localparam int NS = sof_pkg::NUM_SENSORS;

	logic [sof_pkg::LIMIT_BITS-1:0] limit_q;
	logic [NS-1:0][SAMPLE_BITS-1:0] sample;
	logic dev_valid, dev_ready;
	logic [NS-1:0][SAMPLE_BITS+1:0] mag;
	logic [NS-1:0] pos, neg;
	logic sqr_valid, sqr_ready;
	logic [NS-1:0][2*SAMPLE_BITS+3:0] sq;
	logic [2*SAMPLE_BITS+5:0] sq_sum;
	logic [NS-1:0] sq_pos, sq_neg;
	sof_pkg::result_t result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= sof_pkg::LIMIT_RESET;
		end else if (cfg_we) begin
			limit_q <= cfg_wdata;
		end
	end

	always_comb begin
		for (int i = 0; i < NS; i++) begin
			sample[i] = s_tdata[i*SAMPLE_BITS +: SAMPLE_BITS];
		end
	end

	sof_dev #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_dev (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.sample(sample),
		.out_valid(dev_valid),
		.out_ready(dev_ready),
		.mag(mag),
		.pos(pos),
		.neg(neg)
	);

	sof_square #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_square (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(dev_valid),
		.in_ready(dev_ready),
		.mag(mag),
		.pos(pos),
		.neg(neg),
		.out_valid(sqr_valid),
		.out_ready(sqr_ready),
		.sq(sq),
		.sq_sum(sq_sum),
		.pos_out(sq_pos),
		.neg_out(sq_neg)
	);

	sof_judge #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_judge (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(sqr_valid),
		.in_ready(sqr_ready),
		.sq(sq),
		.sq_sum(sq_sum),
		.pos(sq_pos),
		.neg(sq_neg),
		.limit(limit_q),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.result(result)
	);

	assign m_tdata = sof_pkg::OUT_DATA_BITS'(result);

endmodule

### tb/sv/sof_band_checker.sv
`timescale 1ns / 100ps

module sof_band_checker #(
	parameter int IN_BITS = ((sof_pkg::NUM_SENSORS * sof_pkg::SAMPLE_BITS + 7) / 8) * 8
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	input  logic s_tready,
	input  logic [IN_BITS-1:0] s_tdata,
	input  logic m_tvalid,
	input  logic m_tready,
	input  logic [sof_pkg::OUT_DATA_BITS-1:0] m_tdata,
	input  logic cfg_we,
	input  logic [sof_pkg::LIMIT_BITS-1:0] cfg_wdata,
	output int fail_count,
	output int pending,
	output int words_checked,
	output int alarm_words,
	output int flagged_sensors
);

	logic [sof_pkg::LIMIT_BITS-1:0] limit_model;
	sof_pkg::result_t expected_flags_q [$];

	// Works in deviations scaled by four so that the mean never needs a division.
	function automatic sof_pkg::result_t band_flags(input logic [IN_BITS-1:0] readings,
			input logic [sof_pkg::LIMIT_BITS-1:0] lim);
		longint total;
		longint sq_total;
		longint dev [sof_pkg::NUM_SENSORS];
		sof_pkg::result_t r;
		total = 0;
		sq_total = 0;
		r = '0;
		for (int i = 0; i < sof_pkg::NUM_SENSORS; i++) begin
			total += longint'(readings[i*sof_pkg::SAMPLE_BITS +: sof_pkg::SAMPLE_BITS]);
		end
		for (int i = 0; i < sof_pkg::NUM_SENSORS; i++) begin
			dev[i] = 4 * longint'(readings[i*sof_pkg::SAMPLE_BITS +: sof_pkg::SAMPLE_BITS])
				- total;
			sq_total += dev[i] * dev[i];
		end
		r.spread_alarm = sq_total > 64 * longint'(lim);
		if (r.spread_alarm) begin
			for (int i = 0; i < sof_pkg::NUM_SENSORS; i++) begin
				if (4 * dev[i] * dev[i] > sq_total) begin
					if (dev[i] > 0) begin
						r.high_flags[i] = 1'b1;
					end else if (dev[i] < 0) begin
						r.low_flags[i] = 1'b1;
					end
				end
			end
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : monitor
		sof_pkg::result_t got;
		sof_pkg::result_t want;
		int errs;
		if (!arst_n) begin
			limit_model <= sof_pkg::LIMIT_RESET;
			expected_flags_q.delete();
			fail_count <= 0;
			pending <= 0;
			words_checked <= 0;
			alarm_words <= 0;
			flagged_sensors <= 0;
		end else begin
			errs = 0;
			if (cfg_we) begin
				limit_model <= cfg_wdata;
			end
			// Results are matched before new words are queued, so a word can never
			// be compared against its own prediction in the same cycle.
			if (m_tvalid && m_tready) begin
				got = sof_pkg::result_t'(m_tdata[sof_pkg::RESULT_BITS-1:0]);
				words_checked <= words_checked + 1;
				alarm_words <= alarm_words + int'(got.spread_alarm);
				flagged_sensors <= flagged_sensors + $countones(got.high_flags)
					+ $countones(got.low_flags);
				if (m_tdata[sof_pkg::OUT_DATA_BITS-1:sof_pkg::RESULT_BITS] != '0) begin
					$error("fill: expected %h, got %h", 0,
						m_tdata[sof_pkg::OUT_DATA_BITS-1:sof_pkg::RESULT_BITS]);
					errs++;
				end
				if (expected_flags_q.size() == 0) begin
					$error("result word %h arrived with no word outstanding", m_tdata);
					errs++;
				end else begin
					want = expected_flags_q.pop_front();
					if (got.high_flags != want.high_flags) begin
						$error("high_flags: expected %h, got %h", want.high_flags,
							got.high_flags);
						errs++;
					end
					if (got.low_flags != want.low_flags) begin
						$error("low_flags: expected %h, got %h", want.low_flags,
							got.low_flags);
						errs++;
					end
					if (got.spread_alarm != want.spread_alarm) begin
						$error("spread_alarm: expected %b, got %b", want.spread_alarm,
							got.spread_alarm);
						errs++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				expected_flags_q.push_back(band_flags(s_tdata, limit_model));
			end
			fail_count <= fail_count + errs;
			pending <= expected_flags_q.size();
		end
	end

endmodule

### tb/sv/sensor_outlier_flagger_tb.sv
`timescale 1ns / 100ps

module sensor_outlier_flagger_tb;

	localparam int SB = sof_pkg::SAMPLE_BITS;
	localparam int IN_BITS = ((sof_pkg::NUM_SENSORS * SB + 7) / 8) * 8;
	localparam logic [sof_pkg::LIMIT_BITS-1:0] LIMIT_MAX = '1;
	localparam int READING_MAX = (1 << SB) - 1;
	localparam int PHASES = 7;
	localparam int PHASE_WORDS = 240;
	localparam int HOLD_CYCLES = 90;

	typedef logic [sof_pkg::LIMIT_BITS-1:0] limit_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_BITS-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [sof_pkg::OUT_DATA_BITS-1:0] m_tdata;
	logic cfg_we = 1'b0;
	limit_t cfg_wdata = '0;

	int fail_count;
	int pending;
	int words_checked;
	int alarm_words;
	int flagged_sensors;
	int limit_settings = 1;

	bit send_gaps = 1'b1;
	bit ready_gaps = 1'b1;
	bit hold_request = 1'b0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	sensor_outlier_flagger u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	sof_band_checker #(
		.IN_BITS(IN_BITS)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.fail_count(fail_count),
		.pending(pending),
		.words_checked(words_checked),
		.alarm_words(alarm_words),
		.flagged_sensors(flagged_sensors)
	);

	function automatic logic [IN_BITS-1:0] four_readings(input int a, input int b,
			input int c, input int d);
		logic [IN_BITS-1:0] w;
		w = '0;
		w[0*SB +: SB] = a[SB-1:0];
		w[1*SB +: SB] = b[SB-1:0];
		w[2*SB +: SB] = c[SB-1:0];
		w[3*SB +: SB] = d[SB-1:0];
		return w;
	endfunction

	function automatic int clamp_reading(input int v);
		return (v < 0) ? 0 : (v > READING_MAX) ? READING_MAX : v;
	endfunction

	// Tight clusters with the odd outlier are the largest share, as those make the
	// band decisions interesting; the rest is uniform noise, flat, rail and split sets.
	function automatic logic [IN_BITS-1:0] random_readings();
		int r [sof_pkg::NUM_SENSORS];
		int kind;
		int base;
		int spread;
		int pick;
		kind = $urandom_range(0, 9);
		base = $urandom_range(0, READING_MAX);
		spread = $urandom_range(1, 200);
		pick = $urandom_range(0, sof_pkg::NUM_SENSORS - 1);
		for (int i = 0; i < sof_pkg::NUM_SENSORS; i++) begin
			case (kind)
				0, 1, 2: r[i] = $urandom_range(0, READING_MAX);
				7: r[i] = base;
				8: r[i] = $urandom_range(0, 1) ? READING_MAX - $urandom_range(0, 3)
					: $urandom_range(0, 3);
				9: r[i] = (i % 2 == 0) ? base : clamp_reading(base + spread);
				default: r[i] = clamp_reading(base + $urandom_range(0, 2 * spread) - spread);
			endcase
		end
		if (kind >= 3 && kind <= 6 && $urandom_range(0, 1)) begin
			r[pick] = clamp_reading(base + ($urandom_range(0, 1) ? 1 : -1)
				* $urandom_range(100, 700));
		end
		return four_readings(r[0], r[1], r[2], r[3]);
	endfunction

	task automatic send_word(input logic [IN_BITS-1:0] w);
		s_tvalid <= 1'b1;
		s_tdata <= w;
		do @(posedge clk); while (!s_tready);
		if (send_gaps && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	// Every word yields a result, so an empty prediction queue means the
	// pipeline is empty and the limit can be changed safely.
	task automatic write_limit(input limit_t v);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		limit_settings++;
	endtask

	initial begin : receiver
		forever begin
			if (hold_request) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_request = 1'b0;
			end else if (ready_gaps && $urandom_range(0, 3) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
				repeat ($urandom_range(1, 20)) @(posedge clk);
			end
		end
	end

	initial begin : stimulus
		limit_t phase_limit;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Rails, single high or low sensors, split pairs and a quiet set at the
		// reset limit.
		send_word(four_readings(0, 0, 0, 0));
		send_word(four_readings(READING_MAX, READING_MAX, READING_MAX, READING_MAX));
		send_word(four_readings(READING_MAX, 0, 0, 0));
		send_word(four_readings(0, READING_MAX, 0, 0));
		send_word(four_readings(0, 0, READING_MAX, 0));
		send_word(four_readings(0, 0, 0, READING_MAX));
		send_word(four_readings(0, READING_MAX, READING_MAX, READING_MAX));
		send_word(four_readings(READING_MAX, 0, READING_MAX, READING_MAX));
		send_word(four_readings(READING_MAX, READING_MAX, 0, READING_MAX));
		send_word(four_readings(READING_MAX, READING_MAX, READING_MAX, 0));
		// Two against two sits exactly on the one-deviation edge: alarm, no flags.
		send_word(four_readings(0, 0, READING_MAX, READING_MAX));
		send_word(four_readings(READING_MAX, 0, READING_MAX, 0));
		send_word(four_readings(512, 511, 512, 511));
		send_word(four_readings(682, 341, READING_MAX, 0));

		// This set has a scaled variance of exactly 12, so the alarm edge falls
		// between limits 12 and 11.
		write_limit(limit_t'(12));
		send_word(four_readings(0, 0, 0, 8));
		write_limit(limit_t'(11));
		send_word(four_readings(0, 0, 0, 8));
		send_word(four_readings(8, 8, 8, 0));

		// With a zero limit only identical readings stay quiet.
		write_limit('0);
		send_word(four_readings(5, 5, 5, 5));
		send_word(four_readings(5, 5, 5, 6));
		write_limit(LIMIT_MAX);
		send_word(four_readings(0, 0, READING_MAX, READING_MAX));

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: phase_limit = sof_pkg::LIMIT_RESET;
				1: phase_limit = limit_t'($urandom_range(0, 3000));
				2: phase_limit = limit_t'($urandom_range(3000, 40000));
				3: phase_limit = '0;
				4: phase_limit = limit_t'($urandom_range(0, int'(LIMIT_MAX)));
				5: phase_limit = limit_t'(1);
				default: phase_limit = limit_t'($urandom_range(5000, 20000));
			endcase
			write_limit(phase_limit);
			send_gaps = (p != 2) && (p != PHASES - 1);
			ready_gaps = (p != 4) && (p != PHASES - 1);
			// The long receiver stall lets the pipeline fill and push back on the input.
			if (p == 0) begin
				hold_request = 1'b1;
			end
			repeat (PHASE_WORDS) send_word(random_readings());
		end

		drain();
		repeat (20) @(posedge clk);
		$display("Summary: %0d result words over %0d limit settings (0 and %0d included),",
			words_checked, limit_settings, LIMIT_MAX);
		$display("  %0d with the spread alarm raised and %0d sensors flagged in total.",
			alarm_words, flagged_sensors);
		if (fail_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	initial begin : watchdog
		#2000000;
		$display("Verification failed");
		$finish;
	end

endmodule
